/* design/btb_two_level_branch_predictor_defines.svh */
// ----------------------------------------------------------------------------
// BTB predictor assertion macros
// Shared concurrent assertion forms used by the predictor RTL.
// ----------------------------------------------------------------------------
`ifndef BTB_TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH
`define BTB_TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH

// check a property on every clock outside reset
`define BTBTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define BTBTL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* design/btbtl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BTB predictor package
// Types, constants and codes shared by the predictor modules.
// ----------------------------------------------------------------------------
package btbtl_pkg;

  localparam int unsigned BtbEntries = 16;
  localparam int unsigned SlotW      = $clog2(BtbEntries);
  localparam int unsigned TagW       = 32 - 2 - SlotW;
  localparam int unsigned MaxHistory = 8;
  localparam int unsigned TableSize  = 1 << MaxHistory;
  localparam int unsigned RowW       = 2 * TableSize;
  localparam int unsigned NumRows    = BtbEntries + 1;
  localparam int unsigned RowAw      = $clog2(NumRows);
  localparam int unsigned PaddrW     = 5;

  localparam logic [RowAw-1:0] SharedRow = RowAw'(BtbEntries);

  localparam logic [3:0] HistLenReset  = 4'd2;
  localparam logic [4:0] TagLenReset   = 5'd8;
  localparam logic [1:0] CtrInitReset  = 2'd1;

  typedef enum logic [1:0] {
    OpPredict = 2'd0,
    OpUpdate  = 2'd1,
    OpClear   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ShareNone = 2'd0,
    SharePcLo = 2'd1,
    SharePcHi = 2'd2
  } share_e;

  typedef enum logic [2:0] {
    RegHistLen    = 3'd0,
    RegTagLen     = 3'd1,
    RegCtrInit    = 3'd2,
    RegGlobalHist = 3'd3,
    RegGlobalTbl  = 3'd4,
    RegShareMode  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StCount
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] branch_pc;
    logic [31:0] actual_target;
    logic        was_taken;
    logic [31:0] earlier_prediction;
  } btbtl_req_t;

  typedef struct packed {
    logic        predict_taken;
    logic [31:0] predicted_destination;
    logic        flushed;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } btbtl_rsp_t;

  typedef struct packed {
    logic [3:0] history_length;
    logic [4:0] tag_length;
    logic [1:0] counter_initial;
    logic       use_global_history;
    logic       use_global_table;
    logic [1:0] share_mode;
  } btbtl_cfg_t;

  typedef struct packed {
    logic [TagW-1:0]       tag;
    logic [31:0]           target;
    logic [MaxHistory-1:0] history;
  } btbtl_entry_t;

  typedef struct packed {
    logic         valid;
    btbtl_entry_t entry;
  } btbtl_entry_rd_t;

endpackage

/* design/btbtl_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BTB predictor configuration registers
// APB register file holding the predictor mode and size settings.
// ----------------------------------------------------------------------------
module btbtl_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btbtl_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output btbtl_pkg::btbtl_cfg_t          cfg_o
);
  import btbtl_pkg::*;

  btbtl_cfg_t cfg_q, cfg_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegHistLen:    cfg_d.history_length     = pwdata[3:0];
        RegTagLen:     cfg_d.tag_length         = pwdata[4:0];
        RegCtrInit:    cfg_d.counter_initial    = pwdata[1:0];
        RegGlobalHist: cfg_d.use_global_history = pwdata[0];
        RegGlobalTbl:  cfg_d.use_global_table   = pwdata[0];
        RegShareMode:  cfg_d.share_mode         = pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegHistLen:    prdata = {28'd0, cfg_q.history_length};
      RegTagLen:     prdata = {27'd0, cfg_q.tag_length};
      RegCtrInit:    prdata = {30'd0, cfg_q.counter_initial};
      RegGlobalHist: prdata = {31'd0, cfg_q.use_global_history};
      RegGlobalTbl:  prdata = {31'd0, cfg_q.use_global_table};
      RegShareMode:  prdata = {30'd0, cfg_q.share_mode};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.history_length     <= HistLenReset;
      cfg_q.tag_length         <= TagLenReset;
      cfg_q.counter_initial    <= CtrInitReset;
      cfg_q.use_global_history <= 1'b0;
      cfg_q.use_global_table   <= 1'b0;
      cfg_q.share_mode         <= ShareNone;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/btbtl_entry_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BTB predictor entry store
// Direct-mapped tag, target and history memory with per-entry valid flags.
// ----------------------------------------------------------------------------
module btbtl_entry_ram (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             rd_en_i,
  input  logic [btbtl_pkg::SlotW-1:0]      rd_addr_i,
  output btbtl_pkg::btbtl_entry_rd_t       rd_data_o,
  input  logic                             wr_en_i,
  input  logic [btbtl_pkg::SlotW-1:0]      wr_addr_i,
  input  btbtl_pkg::btbtl_entry_t          wr_data_i
);
  import btbtl_pkg::*;

  btbtl_entry_t               mem [BtbEntries];
  logic [BtbEntries-1:0]      valid_q;
  logic                       rd_valid_q;
  btbtl_entry_t               rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o.valid = rd_valid_q;
  assign rd_data_o.entry = rd_entry_q;

endmodule

/* design/btbtl_ctr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BTB predictor counter store
// Row memory of two-bit counters: one row per entry plus the shared row.
// ----------------------------------------------------------------------------
module btbtl_ctr_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [1:0]                    clear_val_i,
  input  logic                          rd_en_i,
  input  logic [btbtl_pkg::RowAw-1:0]   rd_addr_i,
  output logic [btbtl_pkg::RowW-1:0]    rd_data_o,
  input  logic                          wr_en_i,
  input  logic [btbtl_pkg::RowAw-1:0]   wr_addr_i,
  input  logic [btbtl_pkg::RowW-1:0]    wr_data_i
);
  import btbtl_pkg::*;

  logic [RowW-1:0]    mem [NumRows];
  logic [NumRows-1:0] row_wr_q;
  logic [1:0]         fill_q;
  logic               rd_wr_q;
  logic [RowW-1:0]    rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem[rd_addr_i];
    end
  end

  // rows untouched since the last clear read as the fill value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_wr_q <= '0;
      fill_q   <= CtrInitReset;
      rd_wr_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        row_wr_q <= '0;
        fill_q   <= clear_val_i;
      end else if (wr_en_i) begin
        row_wr_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_wr_q <= row_wr_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_wr_q ? rd_row_q : {TableSize{fill_q}};

endmodule

/* design/btb_two_level_branch_predictor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BTB two-level branch predictor
// Direct-mapped BTB with global or per-entry history and counter tables.
//
//   channel   | signals                          | beat taken when
//   ----------+----------------------------------+---------------------------
//   item      | start, busy, req_i               | start && !busy
//   result    | done_o, rsp_o                    | done_o (one cycle)
//   config    | psel penable pwrite paddr pwdata | psel && penable && pwrite
//
// Every item goes from accept to the result strobe in order: a read of the entry
// memory, a read of the counter row it selects, then the write-back.
// busy is high for the counter read and write-back cycles; the next item may
// start in the cycle the result is shown. Clear passes the same steps: valid and
// row flags drop at once. Reset is asynchronous, needs no clearing pass; results
// cannot stall.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  btbtl_pkg::btbtl_req_t          req_i,
  output logic                           done_o,
  output btbtl_pkg::btbtl_rsp_t          rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btbtl_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import btbtl_pkg::*;

`include "btb_two_level_branch_predictor_defines.svh"

  state_e                 state_q, state_d;
  btbtl_req_t             req_q;
  btbtl_rsp_t             rsp_q, rsp_d;
  logic                   done_q;
  logic [31:0]            upd_cnt_q, upd_cnt_d;
  logic [31:0]            flush_cnt_q, flush_cnt_d;
  logic [MaxHistory-1:0]  shared_hist_q, shared_hist_d;

  btbtl_cfg_t             cfg;
  btbtl_entry_rd_t        ent;
  logic [RowW-1:0]        ctr_row;

  logic                   accept;
  logic                   ent_wr_en;
  btbtl_entry_t           ent_wr;
  logic                   ctr_rd_en;
  logic                   ctr_wr_en;
  logic                   clear;
  logic [RowW-1:0]        base_row;
  logic [RowW-1:0]        new_row;

  logic [SlotW-1:0]       slot;
  logic [TagW-1:0]        tag_mask;
  logic [TagW-1:0]        key;
  logic                   hit;
  logic [MaxHistory-1:0]  hmask;
  logic [MaxHistory-1:0]  ent_hist;
  logic [MaxHistory-1:0]  idx;
  logic [RowAw-1:0]       row;
  logic [1:0]             ctr;
  logic [1:0]             ctr_step;
  logic [31:0]            fallthrough;
  logic [31:0]            real_dest;
  logic                   mispredict;
  logic                   is_update;

  btbtl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  btbtl_entry_ram u_entry_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear),
    .rd_en_i   (accept),
    .rd_addr_i (req_i.branch_pc[SlotW+1:2]),
    .rd_data_o (ent),
    .wr_en_i   (ent_wr_en),
    .wr_addr_i (slot),
    .wr_data_i (ent_wr)
  );

  btbtl_ctr_ram u_ctr_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear),
    .clear_val_i (cfg.counter_initial),
    .rd_en_i     (ctr_rd_en),
    .rd_addr_i   (row),
    .rd_data_o   (ctr_row),
    .wr_en_i     (ctr_wr_en),
    .wr_addr_i   (row),
    .wr_data_i   (new_row)
  );

  assign busy      = (state_q != StIdle);
  assign accept    = start && !busy;
  assign is_update = (req_q.operation == OpUpdate);

  // lookup: valid from the cycle after accept until write-back
  always_comb begin
    for (int i = 0; i < TagW; i++) begin
      tag_mask[i] = (5'(i) < cfg.tag_length);
    end
    for (int i = 0; i < MaxHistory; i++) begin
      hmask[i] = (4'(i) < cfg.history_length);
    end
    slot     = req_q.branch_pc[SlotW+1:2];
    key      = req_q.branch_pc[31:SlotW+2] & tag_mask;
    hit      = ent.valid && (ent.entry.tag == key);
    ent_hist = hit ? ent.entry.history : '0;
    idx      = (cfg.use_global_history ? shared_hist_q : ent_hist) & hmask;
    if (cfg.use_global_table) begin
      priority case (cfg.share_mode)
        SharePcLo: idx = idx ^ (req_q.branch_pc[MaxHistory+1:2] & hmask);
        SharePcHi: idx = idx ^ (req_q.branch_pc[MaxHistory+15:16] & hmask);
        default: ;
      endcase
    end
    row = cfg.use_global_table ? SharedRow : {{(RowAw-SlotW){1'b0}}, slot};
  end

  // counter step and write-back data
  always_comb begin
    if (is_update && !hit && !cfg.use_global_table) begin
      base_row = {TableSize{cfg.counter_initial}};
    end else begin
      base_row = ctr_row;
    end
    ctr = base_row[{idx, 1'b0} +: 2];
    if (req_q.was_taken) begin
      ctr_step = (ctr == 2'd3) ? ctr : ctr + 2'd1;
    end else begin
      ctr_step = (ctr == 2'd0) ? ctr : ctr - 2'd1;
    end
    new_row = base_row;
    new_row[{idx, 1'b0} +: 2] = ctr_step;

    fallthrough = req_q.branch_pc + 32'd4;
    real_dest   = req_q.was_taken ? req_q.actual_target : fallthrough;
    mispredict  = (req_q.earlier_prediction != real_dest);

    ent_wr.tag    = key;
    ent_wr.target = req_q.actual_target;
    if (cfg.use_global_history) begin
      ent_wr.history = ent_hist;
    end else begin
      ent_wr.history = {ent_hist[MaxHistory-2:0], req_q.was_taken} & hmask;
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    rsp_d         = rsp_q;
    upd_cnt_d     = upd_cnt_q;
    flush_cnt_d   = flush_cnt_q;
    shared_hist_d = shared_hist_q;
    ctr_rd_en     = 1'b0;
    ctr_wr_en     = 1'b0;
    ent_wr_en     = 1'b0;
    clear         = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        ctr_rd_en = 1'b1;
        state_d   = StCount;
      end
      StCount: begin
        state_d                     = StIdle;
        rsp_d.predict_taken         = 1'b0;
        rsp_d.predicted_destination = 32'd0;
        rsp_d.flushed               = 1'b0;
        unique case (req_q.operation)
          OpPredict: begin
            rsp_d.predicted_destination = fallthrough;
            if (hit && ctr[1]) begin
              rsp_d.predict_taken         = 1'b1;
              rsp_d.predicted_destination = ent.entry.target;
            end
          end
          OpUpdate: begin
            ent_wr_en     = 1'b1;
            ctr_wr_en     = 1'b1;
            upd_cnt_d     = upd_cnt_q + 32'd1;
            rsp_d.flushed = mispredict;
            if (mispredict) begin
              flush_cnt_d = flush_cnt_q + 32'd1;
            end
            if (cfg.use_global_history) begin
              shared_hist_d = {shared_hist_q[MaxHistory-2:0], req_q.was_taken} & hmask;
            end
          end
          OpClear: begin
            clear         = 1'b1;
            shared_hist_d = '0;
          end
          default: ;
        endcase
        rsp_d.branch_count = upd_cnt_d;
        rsp_d.flush_count  = flush_cnt_d;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      done_q        <= 1'b0;
      upd_cnt_q     <= 32'd0;
      flush_cnt_q   <= 32'd0;
      shared_hist_q <= '0;
    end else begin
      state_q       <= state_d;
      done_q        <= (state_q == StCount);
      upd_cnt_q     <= upd_cnt_d;
      flush_cnt_q   <= flush_cnt_d;
      shared_hist_q <= shared_hist_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `BTBTL_ASSERT(a_accept_lookup, accept |=> (state_q == StLookup), "accepted beat not looked up")
  `BTBTL_ASSERT(a_count_done, (state_q == StCount) |=> done_o, "write-back without result beat")
  `BTBTL_ASSERT_NEVER(a_done_busy, done_o && busy, "result beat while busy")
  `BTBTL_ASSERT(a_upd_count, ((state_q == StCount) && is_update) |=> (rsp_o.branch_count == $past(upd_cnt_q) + 32'd1), "branch count did not advance")

endmodule
